### src/ppsb_pkg.sv
package ppsb_pkg;

  localparam int SLOTS         = 8;
  localparam int HANDLE_BITS   = 8;
  localparam int PRIORITY_BITS = 3;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE_HIGH   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAKE_OLD    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DROP_LOW    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DROP_HANDLE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [HANDLE_BITS-1:0]   handle;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

endpackage

### src/priority_packet_slot_buffer.sv
// Packet handle buffer with priorities, kept as a compacted list in arrival order.
// A command is taken when start is high and busy is low; its single result beat
// appears in the cycle after the command finishes, with done high for exactly that
// cycle, and the receiver cannot stall it. Insert and the unused command codes
// finish in the cycle they are taken; a removal from an empty buffer does too.
// Other removals first scan the list and then move later entries down one place,
// both through the single read port of the slot memory, one slot per cycle.
// Take-oldest scans only the first slot, drop-handle stops at the first match,
// and take-highest and drop-lowest scan all held entries before compacting.
// busy drops together with done, so the next command may follow at once.
module priority_packet_slot_buffer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [ppsb_pkg::CMD_W-1:0]             command,
  input  logic [ppsb_pkg::HANDLE_BITS-1:0]       handle_in,
  input  logic [ppsb_pkg::PRIORITY_BITS-1:0]     priority_in,
  output logic                                   done,
  output logic [ppsb_pkg::STATUS_W-1:0]          status,
  output logic [ppsb_pkg::HANDLE_BITS-1:0]       handle_out,
  output logic [ppsb_pkg::PRIORITY_BITS-1:0]     priority_out,
  output logic [ppsb_pkg::CNT_W-1:0]             occupancy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t                             state;
  logic [ppsb_pkg::CNT_W-1:0]         count;
  logic [ppsb_pkg::CMD_W-1:0]         cmd;
  logic [ppsb_pkg::HANDLE_BITS-1:0]   key_handle;
  logic [ppsb_pkg::IDX_W-1:0]         pend_idx;
  logic [ppsb_pkg::CNT_W-1:0]         limit;
  logic [ppsb_pkg::IDX_W-1:0]         best_idx;
  ppsb_pkg::entry_t                   best_entry;

  ppsb_pkg::entry_t                   mem [ppsb_pkg::SLOTS];
  ppsb_pkg::entry_t                   rd_data;

  logic                               accept;
  logic                               hit;
  logic                               take;
  logic                               scan_last;
  logic                               found;
  logic                               sel_is_tail;
  logic                               pend_is_tail;
  logic [ppsb_pkg::IDX_W-1:0]         sel_idx;
  ppsb_pkg::entry_t                   sel_entry;
  logic [ppsb_pkg::CNT_W-1:0]         count_dec;

  logic                               mem_we;
  logic [ppsb_pkg::IDX_W-1:0]         mem_wa;
  ppsb_pkg::entry_t                   mem_wd;
  logic [ppsb_pkg::IDX_W-1:0]         mem_ra;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    count_dec    = count - ppsb_pkg::CNT_W'(1);
    hit          = (rd_data.handle == key_handle);
    unique case (cmd)
      ppsb_pkg::CMD_TAKE_HIGH:
        take = (pend_idx == '0) || (rd_data.prio > best_entry.prio);
      ppsb_pkg::CMD_DROP_LOW:
        take = (pend_idx == '0) || (rd_data.prio < best_entry.prio);
      ppsb_pkg::CMD_DROP_HANDLE:
        take = hit;
      default:
        take = (pend_idx == '0);
    endcase
    sel_idx      = take ? pend_idx : best_idx;
    sel_entry    = take ? rd_data : best_entry;
    found        = (cmd != ppsb_pkg::CMD_DROP_HANDLE) || hit;
    scan_last    = (ppsb_pkg::CNT_W'(pend_idx) == limit - ppsb_pkg::CNT_W'(1)) ||
                   ((cmd == ppsb_pkg::CMD_DROP_HANDLE) && hit);
    sel_is_tail  = (ppsb_pkg::CNT_W'(sel_idx) == count_dec);
    pend_is_tail = (ppsb_pkg::CNT_W'(pend_idx) == count_dec);

    mem_we = 1'b0;
    mem_wa = count[ppsb_pkg::IDX_W-1:0];
    mem_wd = '{handle: handle_in, prio: priority_in};
    mem_ra = '0;
    unique case (state)
      S_IDLE: begin
        mem_we = accept && (command == ppsb_pkg::CMD_INSERT) &&
                 (count < ppsb_pkg::CNT_W'(ppsb_pkg::SLOTS));
      end
      S_SCAN: begin
        mem_ra = scan_last ? (sel_idx + ppsb_pkg::IDX_W'(1))
                           : (pend_idx + ppsb_pkg::IDX_W'(1));
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = pend_idx - ppsb_pkg::IDX_W'(1);
        mem_wd = rd_data;
        mem_ra = pend_idx + ppsb_pkg::IDX_W'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd          <= command;
            key_handle   <= handle_in;
            status       <= ppsb_pkg::ST_DONE;
            handle_out   <= '0;
            priority_out <= '0;
            occupancy    <= count;
            unique case (command) inside
              ppsb_pkg::CMD_INSERT: begin
                done <= 1'b1;
                if (count < ppsb_pkg::CNT_W'(ppsb_pkg::SLOTS)) begin
                  count     <= count + ppsb_pkg::CNT_W'(1);
                  occupancy <= count + ppsb_pkg::CNT_W'(1);
                end else begin
                  status <= ppsb_pkg::ST_FULL;
                end
              end
              ppsb_pkg::CMD_TAKE_HIGH, ppsb_pkg::CMD_TAKE_OLD,
              ppsb_pkg::CMD_DROP_LOW, ppsb_pkg::CMD_DROP_HANDLE: begin
                if (count == '0) begin
                  done   <= 1'b1;
                  status <= ppsb_pkg::ST_NONE;
                end else begin
                  state    <= S_SCAN;
                  pend_idx <= '0;
                  limit    <= (command == ppsb_pkg::CMD_TAKE_OLD) ?
                              ppsb_pkg::CNT_W'(1) : count;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          best_idx   <= sel_idx;
          best_entry <= sel_entry;
          if (scan_last) begin
            if (!found) begin
              state        <= S_IDLE;
              done         <= 1'b1;
              status       <= ppsb_pkg::ST_NONE;
              occupancy    <= count;
            end else if (sel_is_tail) begin
              state        <= S_IDLE;
              done         <= 1'b1;
              count        <= count_dec;
              occupancy    <= count_dec;
              handle_out   <= sel_entry.handle;
              priority_out <= sel_entry.prio;
            end else begin
              state    <= S_SHIFT;
              pend_idx <= sel_idx + ppsb_pkg::IDX_W'(1);
            end
          end else begin
            pend_idx <= pend_idx + ppsb_pkg::IDX_W'(1);
          end
        end
        S_SHIFT: begin
          if (pend_is_tail) begin
            state        <= S_IDLE;
            done         <= 1'b1;
            count        <= count_dec;
            occupancy    <= count_dec;
            handle_out   <= best_entry.handle;
            priority_out <= best_entry.prio;
          end else begin
            pend_idx <= pend_idx + ppsb_pkg::IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ppsb_pkg::CNT_W'(ppsb_pkg::SLOTS))
    else $error("entry count above slot count");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == ppsb_pkg::CMD_INSERT) &&
     (count < ppsb_pkg::CNT_W'(ppsb_pkg::SLOTS)))
    |=> (count == $past(count) + ppsb_pkg::CNT_W'(1)) && done)
    else $error("insert did not add one entry");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ppsb_pkg::ST_FULL))
    |-> (occupancy == ppsb_pkg::CNT_W'(ppsb_pkg::SLOTS)))
    else $error("full reported below capacity");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (ppsb_pkg::CNT_W'(pend_idx) < count) && (pend_idx != '0))
    else $error("compaction index out of range");

endmodule
